/* src/ihex_pkg.sv */
// Shared types and constants for the Intel HEX record loader.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    // Record and transfer limits
    localparam int MAX_RECORD_BYTES   = 32;
    localparam int MAX_TRANSFER_BYTES = 1023;

    localparam int IDX_W  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_RECORD_BYTES + 1);
    localparam int FILL_W = $clog2(MAX_TRANSFER_BYTES + 1);

    // Record byte store: two banks, one being filled while the other drains
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);
    localparam int RAM_AW    = IDX_W + 1;

    // Line counter saturates here
    localparam int COUNT_W   = 9;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    // Text characters
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // ':' + length + offset + type + checksum
    localparam int MIN_LINE_CHARS = 11;
    // Position of the first data digit on the line
    localparam int DATA_POS       = 9;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_RECORD = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ERR_TOO_SHORT  = 3'd3;
    localparam logic [2:0] ERR_NO_EOF     = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd5;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd6;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

    typedef struct packed {
        logic       command;
        logic [7:0] character;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [15:0] transfer_address;
        logic [15:0] byte_address;
        logic [7:0]  byte_value;
        logic        new_transfer;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_DONE,
        JOB_ERROR
    } job_op_t;

    // One finished line handed from the parser to the emitter
    typedef struct packed {
        job_op_t          op;
        logic [2:0]       err_code;
        logic [LEN_W-1:0] len;
        logic [15:0]      offset;
        logic [15:0]      tstart;
        logic             open;
        logic             bank;
        logic             tail;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    // Bank handed back by the emitter after its last read
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

`default_nettype wire

/* src/ihex_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/ihex_front.sv */
// Character parser: tracks line phase, decodes fields, stores data bytes, issues line jobs.
`timescale 1ns / 1ps
`default_nettype none

module ihex_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire ihex_pkg::in_item_t   char_item,
    output logic                      jobq_push,
    output ihex_pkg::job_t            job,
    input  wire logic                 jobq_full,
    output ihex_pkg::ram_wr_t         ram_wr,
    input  wire ihex_pkg::bank_rel_t  rel
);

    import ihex_pkg::*;

    localparam int FSUM_W = FILL_W + 1;

    typedef enum logic [2:0] {
        PH_LINE,
        PH_COMMENT,
        PH_RECORD,
        PH_DONE,
        PH_HALT
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [3:0]          nib_reg, nib_next;
    logic [7:0]          len_reg, len_next;
    logic [15:0]         off_reg, off_next;
    logic [7:0]          type_reg, type_next;
    logic                bad_reg, bad_next;
    logic [15:0]         tstart_reg, tstart_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                bank_reg, bank_next;
    logic [1:0]          busy_reg, busy_next;

    logic                accept;
    logic [7:0]          ch;
    logic [9:0]          data_end;
    logic [9:0]          need;
    logic                too_short;
    logic [15:0]         cont_addr;
    logic [FSUM_W-1:0]   fill_sum;
    logic                open;
    logic                hex_ok;
    logic [3:0]          hex_val;
    logic [COUNT_W-1:0]  rel_pos;
    logic [7:0]          idx;
    logic                set_busy;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    assign accept    = push && !full;
    assign ch        = char_item.character;
    assign full      = (phase_reg == PH_LINE || phase_reg == PH_COMMENT ||
                        phase_reg == PH_RECORD) && (jobq_full || busy_reg[bank_reg]);

    assign data_end  = 10'(DATA_POS) + {1'b0, len_reg, 1'b0};
    assign need      = {1'b0, len_reg, 1'b0} + 10'(MIN_LINE_CHARS);
    assign too_short = need > {1'b0, count_reg};
    assign cont_addr = tstart_reg + 16'(fill_reg);
    assign fill_sum  = {1'b0, fill_reg} + FSUM_W'(len_reg);
    assign open      = (fill_reg == '0) || (off_reg != cont_addr) ||
                       (fill_sum > FSUM_W'(MAX_TRANSFER_BYTES));
    assign {hex_ok, hex_val} = hex_decode(ch);
    assign rel_pos   = count_reg - COUNT_W'(DATA_POS);
    assign idx       = 8'(rel_pos >> 1);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        nib_next    = nib_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        type_next   = type_reg;
        bad_next    = bad_reg;
        tstart_next = tstart_reg;
        fill_next   = fill_reg;
        bank_next   = bank_reg;
        set_busy    = 1'b0;
        jobq_push   = 1'b0;
        job         = '0;
        ram_wr      = '0;

        case (phase_reg)
            PH_LINE:
            begin
                if (accept)
                begin
                    if (char_item.command)
                    begin
                        jobq_push    = 1'b1;
                        job.op       = JOB_ERROR;
                        job.err_code = ERR_NO_EOF;
                        phase_next   = PH_HALT;
                    end
                    else if (ch == CH_HASH)
                    begin
                        phase_next = PH_COMMENT;
                    end
                    else if (ch == CH_COLON)
                    begin
                        phase_next = PH_RECORD;
                        count_next = COUNT_W'(1);
                        len_next   = '0;
                        off_next   = '0;
                        type_next  = '0;
                        nib_next   = '0;
                        bad_next   = 1'b0;
                    end
                    else
                    begin
                        jobq_push    = 1'b1;
                        job.op       = JOB_ERROR;
                        job.err_code = ERR_NOT_RECORD;
                        phase_next   = PH_HALT;
                    end
                end
            end

            PH_COMMENT:
            begin
                if (accept)
                begin
                    if (char_item.command)
                    begin
                        jobq_push    = 1'b1;
                        job.op       = JOB_ERROR;
                        job.err_code = ERR_NO_EOF;
                        phase_next   = PH_HALT;
                    end
                    else if (ch == CH_NEWLINE)
                    begin
                        phase_next = PH_LINE;
                    end
                end
            end

            PH_RECORD:
            begin
                if (accept && (char_item.command || ch == CH_NEWLINE))
                begin
                    // end of line checks, in priority order
                    phase_next = char_item.command ? PH_HALT : PH_LINE;
                    job.op     = JOB_ERROR;
                    if (bad_reg)
                    begin
                        jobq_push    = 1'b1;
                        job.err_code = ERR_BAD_HEX;
                        phase_next   = PH_HALT;
                    end
                    else if (type_reg == REC_EOF)
                    begin
                        jobq_push  = 1'b1;
                        job.op     = JOB_DONE;
                        phase_next = PH_DONE;
                    end
                    else if (type_reg != REC_DATA)
                    begin
                        jobq_push    = 1'b1;
                        job.err_code = ERR_BAD_TYPE;
                        phase_next   = PH_HALT;
                    end
                    else if (len_reg > 8'(MAX_RECORD_BYTES))
                    begin
                        jobq_push    = 1'b1;
                        job.err_code = ERR_TOO_LONG;
                        phase_next   = PH_HALT;
                    end
                    else if (too_short)
                    begin
                        jobq_push    = 1'b1;
                        job.err_code = ERR_TOO_SHORT;
                        phase_next   = PH_HALT;
                    end
                    else if (len_reg == '0)
                    begin
                        if (char_item.command)
                        begin
                            jobq_push    = 1'b1;
                            job.err_code = ERR_NO_EOF;
                        end
                    end
                    else
                    begin
                        jobq_push    = 1'b1;
                        job.op       = JOB_DATA;
                        job.err_code = ERR_NO_EOF;
                        job.len      = LEN_W'(len_reg);
                        job.offset   = off_reg;
                        job.tstart   = open ? off_reg : tstart_reg;
                        job.open     = open;
                        job.bank     = bank_reg;
                        job.tail     = char_item.command;
                        tstart_next  = open ? off_reg : tstart_reg;
                        fill_next    = open ? FILL_W'(len_reg) : FILL_W'(fill_sum);
                        bank_next    = !bank_reg;
                        set_busy     = 1'b1;
                    end
                end
                else if (accept && count_reg != COUNT_W'(COUNT_MAX))
                begin
                    count_next = count_reg + COUNT_W'(1);
                    // characters past the data digits are counted only
                    if (!(count_reg >= COUNT_W'(DATA_POS) && {1'b0, count_reg} >= data_end))
                    begin
                        if (!hex_ok)
                        begin
                            bad_next = 1'b1;
                        end
                        if (count_reg <= COUNT_W'(2))
                        begin
                            len_next = {len_reg[3:0], hex_val};
                        end
                        else if (count_reg <= COUNT_W'(6))
                        begin
                            off_next = {off_reg[11:0], hex_val};
                        end
                        else if (count_reg <= COUNT_W'(8))
                        begin
                            type_next = {type_reg[3:0], hex_val};
                        end
                        else if (count_reg[0])
                        begin
                            nib_next = hex_val;
                        end
                        else if (idx < 8'(MAX_RECORD_BYTES))
                        begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = {bank_reg, idx[IDX_W-1:0]};
                            ram_wr.data = {nib_reg, hex_val};
                        end
                    end
                end
            end

            default:
            begin
            end
        endcase

        busy_next = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (set_busy)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LINE;
            count_reg  <= '0;
            nib_reg    <= '0;
            len_reg    <= '0;
            off_reg    <= '0;
            type_reg   <= '0;
            bad_reg    <= 1'b0;
            tstart_reg <= '0;
            fill_reg   <= '0;
            bank_reg   <= 1'b0;
            busy_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            nib_reg    <= nib_next;
            len_reg    <= len_next;
            off_reg    <= off_next;
            type_reg   <= type_next;
            bad_reg    <= bad_next;
            tstart_reg <= tstart_next;
            fill_reg   <= fill_next;
            bank_reg   <= bank_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

`default_nettype wire

/* src/ihex_jobq.sv */
// Short queue of line jobs between the parser and the emitter.
`timescale 1ns / 1ps
`default_nettype none

module ihex_jobq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ihex_pkg::job_t  job_in,
    output logic                 full,
    input  wire logic            pop,
    output ihex_pkg::job_t       job_out,
    output logic                 empty
);

    import ihex_pkg::*;

    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t               mem_reg [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] wp_reg, wp_next;
    logic [JOBQ_AW-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = cnt_reg == CNT_W'(JOBQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wp_reg + JOBQ_AW'(1);
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rp_reg + JOBQ_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* src/ihex_back.sv */
// Emitter: turns line jobs into result beats, reading record bytes from the store.
`timescale 1ns / 1ps
`default_nettype none

module ihex_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        jobq_empty,
    output logic                             jobq_pop,
    input  wire ihex_pkg::job_t              job,
    output logic                             rd_en,
    output logic [ihex_pkg::RAM_AW-1:0]      rd_addr,
    input  wire logic [7:0]                  rd_data,
    output ihex_pkg::bank_rel_t              rel,
    output logic                             empty,
    input  wire logic                        pop,
    output ihex_pkg::out_item_t              result
);

    import ihex_pkg::*;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1) + 1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DATA,
        B_SINGLE
    } bstate_t;

    bstate_t           state_reg, state_next;
    job_t              job_reg, job_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              stg_valid_reg;
    out_item_t         stg_reg;
    logic              stg_data_reg;
    out_item_t         oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]  wp_reg, rp_reg;
    logic [OQ_CW-1:0]  cnt_reg, cnt_next;

    logic              can_issue;
    logic              issue;
    logic              issue_data;
    out_item_t         meta;
    logic              last_byte;
    logic              oq_wr;
    logic              oq_rd;
    out_item_t         oq_in;

    // room for everything already issued plus this one
    assign can_issue = (cnt_reg + OQ_CW'(stg_valid_reg)) < OQ_CW'(OQ_DEPTH);
    assign last_byte = (idx_reg + LEN_W'(1)) == job_reg.len;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        jobq_pop   = 1'b0;
        issue      = 1'b0;
        issue_data = 1'b0;
        meta       = '0;
        rd_en      = 1'b0;
        rd_addr    = {job_reg.bank, idx_reg[IDX_W-1:0]};
        rel        = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (!jobq_empty)
                begin
                    jobq_pop   = 1'b1;
                    job_next   = job;
                    idx_next   = '0;
                    state_next = (job.op == JOB_DATA) ? B_DATA : B_SINGLE;
                end
            end

            B_DATA:
            begin
                if (can_issue)
                begin
                    issue                 = 1'b1;
                    issue_data            = 1'b1;
                    rd_en                 = 1'b1;
                    meta.kind             = KIND_DATA;
                    meta.error_code       = ERR_NONE;
                    meta.transfer_address = job_reg.tstart;
                    meta.byte_address     = job_reg.offset + 16'(idx_reg);
                    meta.new_transfer     = job_reg.open && (idx_reg == '0);
                    meta.last             = last_byte && !job_reg.tail;
                    idx_next              = idx_reg + LEN_W'(1);
                    if (last_byte)
                    begin
                        rel.valid  = 1'b1;
                        rel.bank   = job_reg.bank;
                        state_next = job_reg.tail ? B_SINGLE : B_IDLE;
                    end
                end
            end

            B_SINGLE:
            begin
                if (can_issue)
                begin
                    issue = 1'b1;
                    if (job_reg.op == JOB_DONE)
                    begin
                        meta.kind       = KIND_DONE;
                        meta.error_code = ERR_NONE;
                    end
                    else
                    begin
                        meta.kind       = KIND_ERROR;
                        meta.error_code = job_reg.err_code;
                    end
                    meta.last  = 1'b1;
                    state_next = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // read data lands in the cycle after issue, alongside the staged beat
    always_comb
    begin
        oq_in            = stg_reg;
        oq_in.byte_value = stg_data_reg ? rd_data : 8'd0;
    end

    assign oq_wr  = stg_valid_reg;
    assign empty  = cnt_reg == '0;
    assign oq_rd  = pop && !empty;
    assign result = oq_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (oq_wr && !oq_rd)
        begin
            cnt_next = cnt_reg + OQ_CW'(1);
        end
        else if (oq_rd && !oq_wr)
        begin
            cnt_next = cnt_reg - OQ_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        stg_reg      <= meta;
        stg_data_reg <= issue_data;
        if (oq_wr)
        begin
            oq_reg[wp_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            stg_valid_reg <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            stg_valid_reg <= issue;
            cnt_reg       <= cnt_next;
            if (oq_wr)
            begin
                wp_reg <= wp_reg + OQ_AW'(1);
            end
            if (oq_rd)
            begin
                rp_reg <= rp_reg + OQ_AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/intel_hex_record_loader_unit.sv */
// Top level of the Intel HEX record loader: parser, job queue, emitter, record byte store.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one text character (or the end-of-input command) per cycle while
// full is low. Data bytes of a record are stored as they are parsed, into
// one of two banks of the record byte store; at the newline the parser
// hands a job to the emitter through a two-entry queue and goes on with the
// next line in the other bank. The emitter pops a job, then puts out one
// beat per cycle, while the four-entry result queue has room, for each data
// byte of a record, or a single beat for a done or error line. The parser
// stalls (full high) only when the job queue is full or when the bank it
// would fill still holds a record not yet read out, so a stream of short
// records keeps up one character per cycle as long as results are popped.
// After the end-of-file record or any error, every later beat is taken and
// dropped. No clearing pass is needed after reset.

module intel_hex_record_loader_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire ihex_pkg::in_item_t   char_item,
    output logic                      empty,
    input  wire logic                 pop,
    output ihex_pkg::out_item_t       result
);

    import ihex_pkg::*;

    logic                jobq_push;
    logic                jobq_full;
    logic                jobq_pop;
    logic                jobq_empty;
    job_t                job_in;
    job_t                job_out;
    ram_wr_t             ram_wr;
    bank_rel_t           rel;
    logic                rd_en;
    logic [RAM_AW-1:0]   rd_addr;
    logic [7:0]          rd_data;

    ihex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .jobq_push (jobq_push),
        .job       (job_in),
        .jobq_full (jobq_full),
        .ram_wr    (ram_wr),
        .rel       (rel)
    );

    ihex_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (jobq_push),
        .job_in  (job_in),
        .full    (jobq_full),
        .pop     (jobq_pop),
        .job_out (job_out),
        .empty   (jobq_empty)
    );

    ihex_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ihex_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .jobq_empty (jobq_empty),
        .jobq_pop   (jobq_pop),
        .job        (job_out),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rel        (rel),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

/* bench/tb_intel_hex_record_loader_unit.sv */
// Self-checking testbench for the Intel HEX record loader unit.
`timescale 1ns / 1ps

module tb_intel_hex_record_loader_unit;

    import ihex_pkg::*;

    typedef logic [7:0] char_t;

    localparam bit CMD_CHAR         = 1'b0;
    localparam bit CMD_END_OF_INPUT = 1'b1;

    localparam int  LONG_HOLD      = 400;
    localparam int  DRAIN_CYCLES   = 64;
    localparam int  CYCLE_LIMIT    = 1000000;
    localparam int  HOLD_REC_BYTES = 12;

    typedef enum logic [2:0] {
        LOADER_LINE_START,
        LOADER_COMMENT,
        LOADER_RECORD,
        LOADER_DONE,
        LOADER_HALTED
    } loader_phase_e;

    // Predicts the result beats of the loader and checks them in order.
    class ihex_scoreboard;
        loader_phase_e phase;
        int            line_count;
        logic [3:0]    nib_hold;
        logic [7:0]    rec_len;
        logic [15:0]   rec_off;
        logic [7:0]    rec_type;
        logic [7:0]    rec_data [MAX_RECORD_BYTES];
        logic [15:0]   xfer_start;
        int            xfer_fill;
        bit            bad_hex;
        out_item_t     expected_beats [$];
        int            mismatches;
        int            data_beats;
        int            done_beats;
        int            error_beats;
        int            ignored_items;

        function new();
            phase      = LOADER_LINE_START;
            line_count = 0;
            nib_hold   = '0;
            rec_len    = '0;
            rec_off    = '0;
            rec_type   = '0;
            foreach (rec_data[i]) rec_data[i] = '0;
            xfer_start = '0;
            xfer_fill  = 0;
            bad_hex    = 1'b0;
            mismatches = 0;
            data_beats = 0;
            done_beats = 0;
            error_beats = 0;
            ignored_items = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void add_beat(logic [1:0] kind, logic [2:0] err, logic [15:0] taddr,
                               logic [15:0] baddr, logic [7:0] value, bit opens, bit tail);
            out_item_t beat;
            beat.kind             = kind;
            beat.error_code       = err;
            beat.transfer_address = taddr;
            beat.byte_address     = baddr;
            beat.byte_value       = value;
            beat.new_transfer     = opens;
            beat.last             = tail;
            expected_beats.push_back(beat);
        endfunction

        function void halt_with(logic [2:0] err);
            add_beat(KIND_ERROR, err, '0, '0, '0, 1'b0, 1'b1);
            phase = LOADER_HALTED;
        endfunction

        function logic [3:0] digit_value(char_t c, output bit ok);
            ok = 1'b1;
            if (c >= "0" && c <= "9") return 4'(c - "0");
            if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
            ok = 1'b0;
            return 4'h0;
        endfunction

        // Closes a record line; returns the number of beats it produced.
        function int close_line();
            int  len;
            bit  opens;
            len   = int'(rec_len);
            phase = LOADER_LINE_START;
            if (bad_hex) begin
                halt_with(ERR_BAD_HEX);
                return 1;
            end
            if (rec_type == REC_EOF) begin
                add_beat(KIND_DONE, ERR_NONE, '0, '0, '0, 1'b0, 1'b1);
                phase = LOADER_DONE;
                return 1;
            end
            if (rec_type != REC_DATA) begin
                halt_with(ERR_BAD_TYPE);
                return 1;
            end
            if (len > MAX_RECORD_BYTES) begin
                halt_with(ERR_TOO_LONG);
                return 1;
            end
            if (2 * len + MIN_LINE_CHARS > line_count) begin
                halt_with(ERR_TOO_SHORT);
                return 1;
            end
            if (len == 0) return 0;
            opens = (xfer_fill == 0) || (rec_off != 16'(xfer_start + xfer_fill))
                    || (xfer_fill + len > MAX_TRANSFER_BYTES);
            if (opens) begin
                xfer_start = rec_off;
                xfer_fill  = 0;
            end
            for (int i = 0; i < len; i++)
                add_beat(KIND_DATA, ERR_NONE, xfer_start, 16'(rec_off + i), rec_data[i],
                         opens && i == 0, i + 1 == len);
            xfer_fill += len;
            return len;
        endfunction

        function void take_record_char(char_t c);
            int         pos;
            int         idx;
            bit         ok;
            logic [3:0] v;
            pos = line_count;
            if (pos >= COUNT_MAX) return;
            line_count = pos + 1;
            // checksum and trailing characters are counted but not decoded
            if (pos >= DATA_POS && pos >= DATA_POS + 2 * int'(rec_len)) return;
            v = digit_value(c, ok);
            if (!ok) bad_hex = 1'b1;
            if (pos <= 2) rec_len = {rec_len[3:0], v};
            else if (pos <= 6) rec_off = {rec_off[11:0], v};
            else if (pos <= 8) rec_type = {rec_type[3:0], v};
            else if (pos % 2 == 1) nib_hold = v;
            else begin
                idx = (pos - DATA_POS) / 2;
                if (idx < MAX_RECORD_BYTES) rec_data[idx] = {nib_hold, v};
            end
        endfunction

        function void note_input(in_item_t beat);
            int        n;
            out_item_t tail_beat;
            if (phase == LOADER_DONE || phase == LOADER_HALTED) begin
                ignored_items++;
                return;
            end
            if (beat.command == CMD_END_OF_INPUT) begin
                if (phase != LOADER_RECORD) begin
                    halt_with(ERR_NO_EOF);
                    return;
                end
                n = close_line();
                if (phase != LOADER_LINE_START) return;
                // the error beat becomes the last one of this input
                if (n > 0) begin
                    tail_beat = expected_beats.pop_back();
                    tail_beat.last = 1'b0;
                    expected_beats.push_back(tail_beat);
                end
                halt_with(ERR_NO_EOF);
                return;
            end
            if (phase == LOADER_COMMENT) begin
                if (beat.character == CH_NEWLINE) phase = LOADER_LINE_START;
                return;
            end
            if (phase == LOADER_LINE_START) begin
                if (beat.character == CH_HASH) begin
                    phase = LOADER_COMMENT;
                    return;
                end
                if (beat.character != CH_COLON) begin
                    halt_with(ERR_NOT_RECORD);
                    return;
                end
                phase      = LOADER_RECORD;
                line_count = 1;
                rec_len    = '0;
                rec_off    = '0;
                rec_type   = '0;
                nib_hold   = '0;
                bad_hex    = 1'b0;
                return;
            end
            if (beat.character == CH_NEWLINE) begin
                void'(close_line());
                return;
            end
            take_record_char(beat.character);
        endfunction

        function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (exp_val !== act_val) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_beat;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: kind %0d error_code %0d",
                       got.kind, got.error_code);
                mismatches++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            compare_field("kind", 16'(exp_beat.kind), 16'(got.kind));
            compare_field("error_code", 16'(exp_beat.error_code), 16'(got.error_code));
            compare_field("transfer_address", exp_beat.transfer_address,
                          got.transfer_address);
            compare_field("byte_address", exp_beat.byte_address, got.byte_address);
            compare_field("byte_value", 16'(exp_beat.byte_value), 16'(got.byte_value));
            compare_field("new_transfer", 16'(exp_beat.new_transfer), 16'(got.new_transfer));
            compare_field("last", 16'(exp_beat.last), 16'(got.last));
            case (exp_beat.kind)
                KIND_DATA: data_beats++;
                KIND_DONE: done_beats++;
                default:   error_beats++;
            endcase
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  char_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    ihex_scoreboard sb = new();

    char_t       line_buf [$];
    bit          sender_calm = 1'b0;
    bit          hold_request = 1'b0;
    int          chars_sent = 0;
    int          cycle_count = 0;
    logic [15:0] next_off;
    string       ending;

    intel_hex_record_loader_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("intel_hex_record_loader_unit regression: fail");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        if (sender_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function char_t hex_char(int v);
        if (v < 10) return char_t'("0" + v);
        if ($urandom_range(0, 1) == 1) return char_t'("a" + v - 10);
        return char_t'("A" + v - 10);
    endfunction

    function bit is_hex(char_t c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // Any character but newline; non-hex when asked.
    function char_t junk_char(bit want_non_hex);
        char_t c;
        do
            c = char_t'($urandom_range(0, 255));
        while (c == CH_NEWLINE || (want_non_hex && is_hex(c)));
        return c;
    endfunction

    function void put_hex(int v, int digits);
        for (int d = digits - 1; d >= 0; d--)
            line_buf.push_back(hex_char((v >> (4 * d)) & 15));
    endfunction

    task automatic send_char(bit cmd, char_t ch);
        in_item_t beat;
        int       gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.command   = cmd;
        beat.character = ch;
        push      <= 1'b1;
        char_item <= beat;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_input(beat);
        chars_sent++;
    endtask

    task automatic send_buf();
        foreach (line_buf[i]) send_char(CMD_CHAR, line_buf[i]);
        line_buf.delete();
    endtask

    task automatic send_comment(int body);
        line_buf.push_back(CH_HASH);
        repeat (body) line_buf.push_back(junk_char(1'b0));
        line_buf.push_back(CH_NEWLINE);
        send_buf();
    endtask

    // ':' len offset type, then data digits, trailing characters, optional newline.
    task automatic send_record(int len, logic [15:0] off, logic [7:0] rtype, int data_digits,
                               int tail, bit with_newline, bit spoil);
        line_buf.push_back(CH_COLON);
        put_hex(len, 2);
        put_hex(int'(off), 4);
        put_hex(int'(rtype), 2);
        repeat (data_digits) line_buf.push_back(hex_char($urandom_range(0, 15)));
        repeat (tail) line_buf.push_back(junk_char(1'b0));
        if (spoil) line_buf[$urandom_range(1, 8 + data_digits)] = junk_char(1'b1);
        if (with_newline) line_buf.push_back(CH_NEWLINE);
        send_buf();
    endtask

    // Stops offering and waits until every predicted beat has been checked.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic send_random_data_record();
        int          len;
        int          r;
        int          tail;
        logic [15:0] off;
        r = $urandom_range(0, 9);
        if (r < 6) len = $urandom_range(1, 4);
        else if (r < 9) len = $urandom_range(5, 12);
        else len = MAX_RECORD_BYTES;
        r = $urandom_range(0, 9);
        if (r < 7) off = next_off;
        else if (r < 9) off = 16'($urandom_range(0, 65535));
        else off = 16'($urandom_range(16'hFFE0, 16'hFFFF));
        tail = 2 + (($urandom_range(0, 9) < 3) ? 1 : 0);
        send_record(len, off, REC_DATA, 2 * len, tail, 1'b1, 1'b0);
        next_off = 16'(off + len);
    endtask

    task automatic send_ending();
        int len;
        int choice;
        choice = $urandom_range(0, 9);
        case (choice)
            0:
            begin
                ending = "end-of-file record";
                send_record(0, '0, REC_EOF, 0, 2, 1'b1, 1'b0);
            end
            1:
            begin
                ending = "end-of-file record cut by end of input";
                len = $urandom_range(0, 3);
                send_record(len, 16'($urandom), REC_EOF, 2 * len, 2, 1'b0, 1'b0);
                send_char(CMD_END_OF_INPUT, junk_char(1'b0));
            end
            2:
            begin
                ending = "end of input at line start";
                send_char(CMD_END_OF_INPUT, char_t'($urandom_range(0, 255)));
            end
            3:
            begin
                ending = "end of input inside a comment";
                line_buf.push_back(CH_HASH);
                line_buf.push_back(junk_char(1'b0));
                send_buf();
                send_char(CMD_END_OF_INPUT, CH_NEWLINE);
            end
            4:
            begin
                ending = "end of input inside a data record";
                len = $urandom_range(1, MAX_RECORD_BYTES);
                send_record(len, next_off, REC_DATA, 2 * len, 2, 1'b0, 1'b0);
                send_char(CMD_END_OF_INPUT, char_t'($urandom_range(0, 255)));
            end
            5:
            begin
                ending = "line not starting a record";
                line_buf.push_back(junk_char(1'b0));
                while (line_buf[0] == CH_HASH || line_buf[0] == CH_COLON)
                    line_buf[0] = char_t'($urandom_range(0, 255));
                send_buf();
            end
            6:
            begin
                ending = "unknown record type";
                len = $urandom_range(0, 4);
                send_record(len, next_off, 8'($urandom_range(2, 255)), 2 * len, 2, 1'b1,
                            1'b0);
            end
            7:
            begin
                ending = "record too long";
                send_record($urandom_range(MAX_RECORD_BYTES + 1, 255), next_off, REC_DATA,
                            $urandom_range(0, 20), 2, 1'b1, 1'b0);
            end
            8:
            begin
                ending = "record too short";
                len = $urandom_range(1, MAX_RECORD_BYTES);
                send_record(len, next_off, REC_DATA, $urandom_range(0, 2 * len - 1), 0,
                            1'b1, 1'b0);
            end
            default:
            begin
                ending = "bad hex digit";
                len = $urandom_range(1, 8);
                send_record(len, next_off, REC_DATA, 2 * len, 2, 1'b1, 1'b1);
            end
        endcase
    endtask

    // Result side: random stalls, calm stretches, one long hold-off on request.
    initial
    begin
        int  stall;
        int  mode_left;
        bit  recv_calm;
        int  r;
        stall     = 0;
        mode_left = 0;
        recv_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) sb.check_result(result);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                stall = 0;
            end
            if (mode_left == 0)
            begin
                recv_calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(100, 300);
            end
            else
                mode_left--;
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                r = $urandom_range(0, 99);
                if (!recv_calm && r < 20) stall = $urandom_range(1, 3);
                else if (!recv_calm && r < 23) stall = $urandom_range(10, 30);
            end
        end
    end

    initial
    begin
        int r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // short directed opening: comment with high bytes, empty first record,
        // then a one-byte record at the top of the address space
        line_buf.push_back(CH_HASH);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        line_buf.push_back(CH_NEWLINE);
        send_buf();
        send_record(0, 16'h0000, REC_DATA, 0, 2, 1'b1, 1'b0);
        send_record(1, 16'hFFFF, REC_DATA, 2, 2, 1'b1, 1'b0);
        next_off = 16'h0000;

        for (int line_no = 0; line_no < 5; line_no++)
        begin
            sender_calm = (line_no == 1);
            if (line_no == 2) wait_drained();
            if (line_no == 3)
            begin
                // receiver held off: one record pins each bank, so the next line stalls
                hold_request = 1'b1;
                send_record(HOLD_REC_BYTES, next_off, REC_DATA, 2 * HOLD_REC_BYTES,
                            2, 1'b1, 1'b0);
                next_off = 16'(next_off + HOLD_REC_BYTES);
                send_record(1, next_off, REC_DATA, 2, 2, 1'b1, 1'b0);
                next_off = 16'(next_off + 1);
            end
            r = $urandom_range(0, 99);
            if (r < 10)
                send_comment($urandom_range(0, 6));
            else if (r < 15)
                send_record(0, 16'($urandom), REC_DATA, 0, 2, 1'b1, 1'b0);
            else
                send_random_data_record();
        end

        send_ending();
        // the block is finished now; these must give nothing
        repeat (10) send_char(1'($urandom_range(0, 1)), char_t'($urandom_range(0, 255)));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters (%0d ignored after the stream ended by %s).",
                 chars_sent, sb.ignored_items, ending);
        $display("Checked %0d data beats, %0d done beats, %0d error beats.",
                 sb.data_beats, sb.done_beats, sb.error_beats);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("intel_hex_record_loader_unit regression: pass");
        else
            $display("intel_hex_record_loader_unit regression: fail");
        $finish;
    end

endmodule
